// ----- src/assert_macros.svh -----
// Assertion helpers included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition holds whenever a qualifier is high
`define ASSERT_WHEN(label, clk, rst, qual, cond, msg) \
   `ASSERT_CLK(label, clk, rst, (qual) |-> (cond), msg)

`endif

// ----- src/lar_pkg.sv -----
package lar_pkg;

   // Field widths
   localparam int HUM_W  = 10;
   localparam int TEMP_W = 11;
   localparam int CNT_W  = 7;
   localparam int CH_N   = 4;
   localparam int CSR_W  = 11;

   // Channel bit positions in every mask
   localparam int CH_HUM_HIGH  = 0;
   localparam int CH_HUM_LOW   = 1;
   localparam int CH_TEMP_HIGH = 2;
   localparam int CH_TEMP_LOW  = 3;

   // Register indexes
   typedef enum logic [2:0] {
      CSR_HUM_HIGH  = 3'd0,
      CSR_HUM_LOW   = 3'd1,
      CSR_TEMP_HIGH = 3'd2,
      CSR_TEMP_LOW  = 3'd3,
      CSR_REARM     = 3'd4
   } csr_index_type;

   // Values after reset
   localparam logic [HUM_W-1:0]         HUM_HIGH_RST  = 10'd600;
   localparam logic [HUM_W-1:0]         HUM_LOW_RST   = 10'd400;
   localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RST = 11'sd300;
   localparam logic signed [TEMP_W-1:0] TEMP_LOW_RST  = 11'sd200;
   localparam logic [CNT_W-1:0]         REARM_RST     = 7'd120;
   localparam logic [CH_N-1:0]          ARMED_RST     = 4'b1111;

endpackage

// ----- src/limit_alarm_with_timed_rearm.sv -----
// An accepted item is held in the input register, then its result is
// registered in the result stage, which drives the response channel.
// Throughput: one item per cycle when not stalled; the armed flags and
// re-arm counters update in the same cycle an item leaves the input register.
// Reset (synchronous, active high): all channels armed, counters zero,
// limits and re-arm count back to defaults, both stages empty.
module limit_alarm_with_timed_rearm (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_we,
   input  logic [2:0]                        csr_index,
   input  logic [lar_pkg::CSR_W-1:0]         csr_wdata,
   // readings
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [lar_pkg::HUM_W-1:0]         req_humidity,
   input  logic signed [lar_pkg::TEMP_W-1:0] req_temperature,
   input  logic                              req_reading_valid,
   // results
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lar_pkg::CH_N-1:0]          rsp_fired_mask,
   output logic [lar_pkg::CH_N-1:0]          rsp_rearmed_mask,
   output logic [lar_pkg::CH_N-1:0]          rsp_armed_mask,
   output logic [lar_pkg::CNT_W-1:0]         rsp_hum_high_count,
   output logic [lar_pkg::CNT_W-1:0]         rsp_hum_low_count,
   output logic [lar_pkg::CNT_W-1:0]         rsp_temp_high_count,
   output logic [lar_pkg::CNT_W-1:0]         rsp_temp_low_count
);

   // configuration registers
   logic [lar_pkg::HUM_W-1:0]         hum_high_ff, hum_low_ff;
   logic signed [lar_pkg::TEMP_W-1:0] temp_high_ff, temp_low_ff;
   logic [lar_pkg::CNT_W-1:0]         rearm_ff;

   // alarm state
   logic [lar_pkg::CH_N-1:0]                    armed_ff, armed_in;
   logic [lar_pkg::CH_N-1:0][lar_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   // input stage
   logic                              in_valid_ff, in_valid_in;
   logic [lar_pkg::HUM_W-1:0]         in_hum_ff;
   logic signed [lar_pkg::TEMP_W-1:0] in_temp_ff;
   logic                              in_rv_ff;

   // result stage
   logic                              out_valid_ff, out_valid_in;
   logic [lar_pkg::CH_N-1:0]          fired_ff, fired_in;
   logic [lar_pkg::CH_N-1:0]          rearmed_ff, rearmed_in;
   logic [lar_pkg::CH_N-1:0]          armed_out_ff;
   logic [lar_pkg::CH_N-1:0][lar_pkg::CNT_W-1:0] cnt_out_ff;

   logic                              req_take, out_free, step;
   logic [lar_pkg::CH_N-1:0]          beyond;
   logic [lar_pkg::CH_N-1:0][lar_pkg::CNT_W-1:0] cnt_inc;

   // handshake between stages
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // compare the held reading against each limit
   always_comb begin
      beyond[lar_pkg::CH_HUM_HIGH]  = in_hum_ff >= hum_high_ff;
      beyond[lar_pkg::CH_HUM_LOW]   = in_hum_ff <= hum_low_ff;
      beyond[lar_pkg::CH_TEMP_HIGH] = in_temp_ff >= temp_high_ff;
      beyond[lar_pkg::CH_TEMP_LOW]  = in_temp_ff <= temp_low_ff;
   end

   // per channel: fire when armed, else count in-limit readings and re-arm
   always_comb begin
      armed_in   = armed_ff;
      cnt_in     = cnt_ff;
      fired_in   = '0;
      rearmed_in = '0;
      for (int i = 0; i < lar_pkg::CH_N; i++) begin
         cnt_inc[i] = cnt_ff[i] + lar_pkg::CNT_W'(1);
         if (step && in_rv_ff) begin
            if (armed_ff[i]) begin
               if (beyond[i]) begin
                  armed_in[i] = 1'b0;
                  fired_in[i] = 1'b1;
               end
            end else if (beyond[i]) begin
               cnt_in[i] = '0;
            end else if (cnt_inc[i] == rearm_ff) begin
               armed_in[i]   = 1'b1;
               cnt_in[i]     = '0;
               rearmed_in[i] = 1'b1;
            end else begin
               cnt_in[i] = cnt_inc[i];
            end
         end
      end
   end

   // stage occupancy
   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else begin
         in_valid_in = in_valid_ff && !step;
      end
      if (step) begin
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = out_valid_ff && rsp_stall;
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         armed_ff     <= lar_pkg::ARMED_RST;
         cnt_ff       <= '0;
         hum_high_ff  <= lar_pkg::HUM_HIGH_RST;
         hum_low_ff   <= lar_pkg::HUM_LOW_RST;
         temp_high_ff <= lar_pkg::TEMP_HIGH_RST;
         temp_low_ff  <= lar_pkg::TEMP_LOW_RST;
         rearm_ff     <= lar_pkg::REARM_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         armed_ff     <= armed_in;
         cnt_ff       <= cnt_in;
         if (csr_we) begin
            case (csr_index)
               lar_pkg::CSR_HUM_HIGH:  hum_high_ff  <= csr_wdata[lar_pkg::HUM_W-1:0];
               lar_pkg::CSR_HUM_LOW:   hum_low_ff   <= csr_wdata[lar_pkg::HUM_W-1:0];
               lar_pkg::CSR_TEMP_HIGH: temp_high_ff <= $signed(csr_wdata[lar_pkg::TEMP_W-1:0]);
               lar_pkg::CSR_TEMP_LOW:  temp_low_ff  <= $signed(csr_wdata[lar_pkg::TEMP_W-1:0]);
               lar_pkg::CSR_REARM:     rearm_ff     <= csr_wdata[lar_pkg::CNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers: capture the item, then hold the result
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_hum_ff  <= req_humidity;
         in_temp_ff <= req_temperature;
         in_rv_ff   <= req_reading_valid;
      end
      if (step) begin
         fired_ff     <= fired_in;
         rearmed_ff   <= rearmed_in;
         armed_out_ff <= armed_in;
         cnt_out_ff   <= cnt_in;
      end
   end

   // drive the result channel
   assign rsp_valid           = out_valid_ff;
   assign rsp_fired_mask      = fired_ff;
   assign rsp_rearmed_mask    = rearmed_ff;
   assign rsp_armed_mask      = armed_out_ff;
   assign rsp_hum_high_count  = cnt_out_ff[lar_pkg::CH_HUM_HIGH];
   assign rsp_hum_low_count   = cnt_out_ff[lar_pkg::CH_HUM_LOW];
   assign rsp_temp_high_count = cnt_out_ff[lar_pkg::CH_TEMP_HIGH];
   assign rsp_temp_low_count  = cnt_out_ff[lar_pkg::CH_TEMP_LOW];

endmodule

// ----- src/lar_checker.sv -----
`include "assert_macros.svh"

module lar_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [lar_pkg::CH_N-1:0]          rsp_fired_mask,
   input  logic [lar_pkg::CH_N-1:0]          rsp_rearmed_mask,
   input  logic [lar_pkg::CH_N-1:0]          rsp_armed_mask,
   input  logic [lar_pkg::CNT_W-1:0]         rsp_hum_high_count,
   input  logic [lar_pkg::CNT_W-1:0]         rsp_hum_low_count,
   input  logic [lar_pkg::CNT_W-1:0]         rsp_temp_high_count,
   input  logic [lar_pkg::CNT_W-1:0]         rsp_temp_low_count
);

   logic rsp_wait, req_wait, fire_ok, rearm_ok, count_ok;
   logic [3*lar_pkg::CH_N+4*lar_pkg::CNT_W-1:0] rsp_payload;

   // gather the result item and the per-item consistency terms
   assign rsp_wait    = rsp_valid && rsp_stall;
   assign req_wait    = req_valid && req_stall;
   assign rsp_payload = {rsp_fired_mask, rsp_rearmed_mask, rsp_armed_mask,
                         rsp_hum_high_count, rsp_hum_low_count,
                         rsp_temp_high_count, rsp_temp_low_count};
   assign fire_ok     = (rsp_fired_mask & rsp_armed_mask) == '0;
   assign rearm_ok    = (rsp_rearmed_mask & ~rsp_armed_mask) == '0 &&
                        (rsp_rearmed_mask & rsp_fired_mask) == '0;
   assign count_ok    =
      (!rsp_armed_mask[lar_pkg::CH_HUM_HIGH]  || rsp_hum_high_count == '0) &&
      (!rsp_armed_mask[lar_pkg::CH_HUM_LOW]   || rsp_hum_low_count == '0) &&
      (!rsp_armed_mask[lar_pkg::CH_TEMP_HIGH] || rsp_temp_high_count == '0) &&
      (!rsp_armed_mask[lar_pkg::CH_TEMP_LOW]  || rsp_temp_low_count == '0);

   // a stalled result stays and holds its payload
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_wait |=> rsp_valid && $stable(rsp_payload), "item changed")

   // the input only stalls while a result is held off
   `ASSERT_WHEN(a_req_stall_cause, clock, reset, req_wait, rsp_wait, "input stalled without cause")

   // a channel that fired is left disarmed
   `ASSERT_WHEN(a_fired_disarmed, clock, reset, rsp_valid, fire_ok, "fired channel still armed")

   // a channel that re-armed is armed and did not fire
   `ASSERT_WHEN(a_rearmed_armed, clock, reset, rsp_valid, rearm_ok, "re-arm mask inconsistent")

   // an armed channel keeps its counter at zero
   `ASSERT_WHEN(a_armed_count_zero, clock, reset, rsp_valid, count_ok, "armed channel has count")

endmodule

bind limit_alarm_with_timed_rearm lar_checker u_lar_checker (.*);

// ----- tb/sv/limit_alarm_with_timed_rearm_tb.sv -----
module limit_alarm_with_timed_rearm_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 500000;
   localparam int SHOWN_MAX = 10;
   localparam int HOLD_CYCLES = 250;
   localparam int HOLD_SPACING = 700;
   localparam int HUM_SPAN = 1 << lar_pkg::HUM_W;
   localparam int TEMP_SPAN = 1 << lar_pkg::TEMP_W;
   // register indexes the block does not implement
   localparam logic [2:0] CSR_SPARE_LO = 3'd5;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [lar_pkg::HUM_W-1:0]         humidity;
      logic signed [lar_pkg::TEMP_W-1:0] temperature;
      logic                              reading_ok;
   } reading_type;

   typedef struct packed {
      logic [lar_pkg::CH_N-1:0]  fired;
      logic [lar_pkg::CH_N-1:0]  rearmed;
      logic [lar_pkg::CH_N-1:0]  armed;
      logic [lar_pkg::CNT_W-1:0] hum_high_cnt;
      logic [lar_pkg::CNT_W-1:0] hum_low_cnt;
      logic [lar_pkg::CNT_W-1:0] temp_high_cnt;
      logic [lar_pkg::CNT_W-1:0] temp_low_cnt;
   } alarm_result_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_HALF,
      STALL_QUARTER,
      STALL_PATTERN
   } stall_mode_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_we = 1'b0;
   logic [2:0]                        csr_index = '0;
   logic [lar_pkg::CSR_W-1:0]         csr_wdata = '0;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [lar_pkg::HUM_W-1:0]         req_humidity = '0;
   logic signed [lar_pkg::TEMP_W-1:0] req_temperature = '0;
   logic                              req_reading_valid = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [lar_pkg::CH_N-1:0]          rsp_fired_mask;
   logic [lar_pkg::CH_N-1:0]          rsp_rearmed_mask;
   logic [lar_pkg::CH_N-1:0]          rsp_armed_mask;
   logic [lar_pkg::CNT_W-1:0]         rsp_hum_high_count;
   logic [lar_pkg::CNT_W-1:0]         rsp_hum_low_count;
   logic [lar_pkg::CNT_W-1:0]         rsp_temp_high_count;
   logic [lar_pkg::CNT_W-1:0]         rsp_temp_low_count;

   // alarm state and limits as the block should hold them
   logic [lar_pkg::HUM_W-1:0]         cfg_hum_high = lar_pkg::HUM_HIGH_RST;
   logic [lar_pkg::HUM_W-1:0]         cfg_hum_low = lar_pkg::HUM_LOW_RST;
   logic signed [lar_pkg::TEMP_W-1:0] cfg_temp_high = lar_pkg::TEMP_HIGH_RST;
   logic signed [lar_pkg::TEMP_W-1:0] cfg_temp_low = lar_pkg::TEMP_LOW_RST;
   logic [lar_pkg::CNT_W-1:0]         cfg_rearm = lar_pkg::REARM_RST;
   logic [lar_pkg::CH_N-1:0]          alarm_armed = lar_pkg::ARMED_RST;
   logic [lar_pkg::CNT_W-1:0]         rearm_counter [lar_pkg::CH_N] = '{default: '0};

   reading_type                       readings_to_send [$];
   alarm_result_type                  alarm_results_due [$];
   reading_type                       send_slot;
   alarm_result_type                  seen_result;
   alarm_result_type                  due_result;

   int                                burst_left = 0;
   int                                gap_left = 0;
   int                                rsp_seen = 0;
   int                                mismatch_count = 0;
   int                                cycle_count = 0;
   int                                hold_left = 0;
   int                                next_hold_at = 120;
   int                                mode_left = 0;
   stall_mode_type                    stall_mode = STALL_NONE;
   logic [7:0]                        stall_pattern = 8'b1100_1010;

   limit_alarm_with_timed_rearm dut (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_humidity        (req_humidity),
      .req_temperature     (req_temperature),
      .req_reading_valid   (req_reading_valid),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_fired_mask      (rsp_fired_mask),
      .rsp_rearmed_mask    (rsp_rearmed_mask),
      .rsp_armed_mask      (rsp_armed_mask),
      .rsp_hum_high_count  (rsp_hum_high_count),
      .rsp_hum_low_count   (rsp_hum_low_count),
      .rsp_temp_high_count (rsp_temp_high_count),
      .rsp_temp_low_count  (rsp_temp_low_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the alarm channels by one reading and queue the result it gives
   task automatic step_alarm_model(logic [lar_pkg::HUM_W-1:0] hum,
                                   logic signed [lar_pkg::TEMP_W-1:0] temp,
                                   logic ok);
      logic [lar_pkg::CH_N-1:0] beyond;
      logic [lar_pkg::CH_N-1:0] fired;
      logic [lar_pkg::CH_N-1:0] rearmed;
      alarm_result_type         res;
      fired = '0;
      rearmed = '0;
      if (ok) begin
         beyond[lar_pkg::CH_HUM_HIGH] = hum >= cfg_hum_high;
         beyond[lar_pkg::CH_HUM_LOW] = hum <= cfg_hum_low;
         beyond[lar_pkg::CH_TEMP_HIGH] = temp >= cfg_temp_high;
         beyond[lar_pkg::CH_TEMP_LOW] = temp <= cfg_temp_low;
         for (int ch = 0; ch < lar_pkg::CH_N; ch++) begin
            if (alarm_armed[ch]) begin
               // an armed channel only watches for the limit
               if (beyond[ch]) begin
                  alarm_armed[ch] = 1'b0;
                  fired[ch] = 1'b1;
               end
            end else if (beyond[ch]) begin
               rearm_counter[ch] = '0;
            end else begin
               // count in-limit readings, wrapping at the counter width
               rearm_counter[ch] = rearm_counter[ch] + 1'b1;
               if (rearm_counter[ch] == cfg_rearm) begin
                  alarm_armed[ch] = 1'b1;
                  rearm_counter[ch] = '0;
                  rearmed[ch] = 1'b1;
               end
            end
         end
      end
      res.fired = fired;
      res.rearmed = rearmed;
      res.armed = alarm_armed;
      res.hum_high_cnt = rearm_counter[lar_pkg::CH_HUM_HIGH];
      res.hum_low_cnt = rearm_counter[lar_pkg::CH_HUM_LOW];
      res.temp_high_cnt = rearm_counter[lar_pkg::CH_TEMP_HIGH];
      res.temp_low_cnt = rearm_counter[lar_pkg::CH_TEMP_LOW];
      alarm_results_due.push_back(res);
   endtask

   // Write one register and track it in the expected limits
   task automatic write_reg(logic [2:0] idx, logic [lar_pkg::CSR_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         lar_pkg::CSR_HUM_HIGH:  cfg_hum_high = data[lar_pkg::HUM_W-1:0];
         lar_pkg::CSR_HUM_LOW:   cfg_hum_low = data[lar_pkg::HUM_W-1:0];
         lar_pkg::CSR_TEMP_HIGH: cfg_temp_high = data[lar_pkg::TEMP_W-1:0];
         lar_pkg::CSR_TEMP_LOW:  cfg_temp_low = data[lar_pkg::TEMP_W-1:0];
         lar_pkg::CSR_REARM:     cfg_rearm = data[lar_pkg::CNT_W-1:0];
         default:                ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic program_limits(int hum_hi, int hum_lo, int temp_hi, int temp_lo,
                                 int rearm);
      write_reg(lar_pkg::CSR_HUM_HIGH, lar_pkg::CSR_W'(hum_hi));
      write_reg(lar_pkg::CSR_HUM_LOW, lar_pkg::CSR_W'(hum_lo));
      write_reg(lar_pkg::CSR_TEMP_HIGH, lar_pkg::CSR_W'(temp_hi));
      write_reg(lar_pkg::CSR_TEMP_LOW, lar_pkg::CSR_W'(temp_lo));
      write_reg(lar_pkg::CSR_REARM, lar_pkg::CSR_W'(rearm));
   endtask

   // Hold until every item is sent and every result is back, then settle
   task automatic wait_idle();
      @(negedge clock);
      while (readings_to_send.size() != 0 || req_valid || alarm_results_due.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic push_reading(int hum, int temp, bit ok);
      reading_type r;
      r.humidity = hum[lar_pkg::HUM_W-1:0];
      r.temperature = temp[lar_pkg::TEMP_W-1:0];
      r.reading_ok = ok;
      readings_to_send.push_back(r);
   endtask

   function automatic int inside_hum();
      int lo;
      int hi;
      lo = int'(cfg_hum_low);
      hi = int'(cfg_hum_high);
      if (hi - lo >= 2)
         return int'($urandom_range(lo + 1, hi - 1));
      return int'($urandom_range(0, HUM_SPAN - 1));
   endfunction

   function automatic int inside_temp();
      int lo;
      int hi;
      lo = int'(cfg_temp_low);
      hi = int'(cfg_temp_high);
      if (hi - lo >= 2)
         return lo + 1 + int'($urandom_range(0, hi - lo - 2));
      return int'($urandom_range(0, TEMP_SPAN - 1)) - TEMP_SPAN / 2;
   endfunction

   // One reading that reaches a chosen channel's limit, exactly or past it
   task automatic push_excursion();
      int  hum;
      int  temp;
      bit  exact;
      hum = inside_hum();
      temp = inside_temp();
      exact = $urandom_range(0, 1);
      case (int'($urandom_range(0, lar_pkg::CH_N - 1)))
         lar_pkg::CH_HUM_HIGH:
            hum = exact ? int'(cfg_hum_high) :
                  int'($urandom_range(cfg_hum_high, HUM_SPAN - 1));
         lar_pkg::CH_HUM_LOW:
            hum = exact ? int'(cfg_hum_low) : int'($urandom_range(0, cfg_hum_low));
         lar_pkg::CH_TEMP_HIGH:
            temp = exact ? int'(cfg_temp_high) :
                   int'($urandom_range(int'(cfg_temp_high) + TEMP_SPAN / 2, TEMP_SPAN - 1))
                   - TEMP_SPAN / 2;
         default:
            temp = exact ? int'(cfg_temp_low) :
                   int'($urandom_range(0, int'(cfg_temp_low) + TEMP_SPAN / 2)) - TEMP_SPAN / 2;
      endcase
      push_reading(hum, temp, 1'b1);
   endtask

   // Mostly in-limit runs around the re-arm count, broken by excursions and noise
   task automatic queue_traffic(int n);
      int produced;
      int kind;
      int len;
      int rc;
      produced = 0;
      rc = (cfg_rearm == 0) ? (1 << lar_pkg::CNT_W) : int'(cfg_rearm);
      while (produced < n) begin
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            len = ($urandom_range(0, 1) == 0) ? $urandom_range(1, rc + 3) :
                                                 $urandom_range(rc, rc + 3);
            repeat (len) begin
               if ($urandom_range(0, 15) == 0)
                  push_reading($urandom, $urandom, 1'b0);
               else
                  push_reading(inside_hum(), inside_temp(), 1'b1);
            end
            produced += len;
         end else if (kind <= 7) begin
            push_excursion();
            produced++;
         end else begin
            push_reading($urandom, $urandom, kind == 9);
            produced++;
         end
      end
   endtask

   // Sender: offer queued items in bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall)
            step_alarm_model(req_humidity, req_temperature, req_reading_valid);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (readings_to_send.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               send_slot = readings_to_send.pop_front();
               req_humidity <= send_slot.humidity;
               req_temperature <= send_slot.temperature;
               req_reading_valid <= send_slot.reading_ok;
               req_valid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 80 : 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // Receiver: stall on a changing pattern, with a few long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_seen >= next_hold_at) begin
         hold_left = HOLD_CYCLES;
         next_hold_at += HOLD_SPACING;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 100);
            stall_pattern = $urandom;
         end else begin
            mode_left--;
         end
         stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
         case (stall_mode)
            STALL_NONE:    rsp_stall <= 1'b0;
            STALL_HALF:    rsp_stall <= $urandom_range(0, 1);
            STALL_QUARTER: rsp_stall <= ($urandom_range(0, 3) == 0);
            default:       rsp_stall <= stall_pattern[0];
         endcase
      end
   end

   // Monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_result.fired = rsp_fired_mask;
         seen_result.rearmed = rsp_rearmed_mask;
         seen_result.armed = rsp_armed_mask;
         seen_result.hum_high_cnt = rsp_hum_high_count;
         seen_result.hum_low_cnt = rsp_hum_low_count;
         seen_result.temp_high_cnt = rsp_temp_high_count;
         seen_result.temp_low_cnt = rsp_temp_low_count;
         if (alarm_results_due.size() == 0) begin
            if (mismatch_count < SHOWN_MAX)
               $display("result %0d arrived with nothing expected", rsp_seen);
            mismatch_count++;
         end else begin
            due_result = alarm_results_due.pop_front();
            if (seen_result !== due_result) begin
               if (mismatch_count < SHOWN_MAX) begin
                  $display("result %0d mismatch", rsp_seen);
                  $display("  expected fired=%h rearmed=%h armed=%h counts=%0d %0d %0d %0d",
                           due_result.fired, due_result.rearmed, due_result.armed,
                           due_result.hum_high_cnt, due_result.hum_low_cnt,
                           due_result.temp_high_cnt, due_result.temp_low_cnt);
                  $display("  actual   fired=%h rearmed=%h armed=%h counts=%0d %0d %0d %0d",
                           seen_result.fired, seen_result.rearmed, seen_result.armed,
                           seen_result.hum_high_cnt, seen_result.hum_low_cnt,
                           seen_result.temp_high_cnt, seen_result.temp_low_cnt);
               end
               mismatch_count++;
            end
         end
         rsp_seen++;
      end
   end

   // Drop the run if it hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // limits at their reset values: edges, exact hits, invalid readings
      push_reading(500, 250, 1'b1);
      push_reading(600, 250, 1'b1);
      push_reading(400, 250, 1'b1);
      push_reading(500, 300, 1'b1);
      push_reading(500, 200, 1'b1);
      push_reading(0, -1024, 1'b0);
      push_reading(1023, 1023, 1'b0);
      push_reading(1023, 250, 1'b1);
      push_reading(0, -1024, 1'b1);
      push_reading(1023, 1023, 1'b1);
      push_reading(599, 299, 1'b1);
      push_reading(401, 201, 1'b1);
      wait_idle();
      // re-arm on the first in-limit reading
      write_reg(lar_pkg::CSR_REARM, lar_pkg::CSR_W'(1));
      push_reading(500, 250, 1'b1);
      push_reading(500, 250, 1'b1);
      push_reading(600, 200, 1'b1);
      push_reading(500, 250, 1'b0);
      push_reading(500, 250, 1'b1);
      wait_idle();
      // writes to unimplemented indexes must not disturb anything
      write_reg(CSR_SPARE_LO, '1);
      write_reg(CSR_SPARE_HI, '0);
      push_reading(400, 200, 1'b1);
      push_reading(550, 250, 1'b1);
      wait_idle();

      program_limits(600, 400, 300, 200, 3);
      queue_traffic(200);
      wait_idle();

      // widest stated limits
      program_limits(1000, 0, 800, -400, 1);
      queue_traffic(150);
      wait_idle();

      program_limits(700, 300, 500, -100, 127);
      queue_traffic(250);
      wait_idle();

      // a re-arm count of 128 masks to zero: re-arm on counter wrap
      program_limits(650, 350, 250, 150, 128);
      queue_traffic(300);
      wait_idle();

      // lower the re-arm count under counters already running
      program_limits(800, 200, 600, 0, 100);
      queue_traffic(150);
      wait_idle();
      write_reg(lar_pkg::CSR_REARM, lar_pkg::CSR_W'(5));
      queue_traffic(200);
      wait_idle();

      // limits outside the stated ranges, with extra bits in the write data
      program_limits(0, 'h7FF, -1024, 1023, 2);
      queue_traffic(60);
      wait_idle();
      program_limits(1023, 0, 1023, -1024, 2);
      queue_traffic(100);
      wait_idle();

      // random limit settings
      repeat (3) begin
         int hum_lo;
         int temp_lo;
         hum_lo = $urandom_range(0, 600);
         temp_lo = int'($urandom_range(0, 800)) - 400;
         program_limits(hum_lo + int'($urandom_range(2, 400)), hum_lo,
                        temp_lo + int'($urandom_range(2, 400)), temp_lo,
                        $urandom_range(1, 12));
         queue_traffic(120);
         wait_idle();
      end

      repeat (6) @(posedge clock);
      if (mismatch_count == 0 && alarm_results_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
